FILE: rtl/core/bcr_pkg.sv
// Package for the byte-code register machine: sizes, codes, payload types and helpers.
`timescale 1ns / 1ps
package bcr_pkg;

	// Memory sizes; RAM_DEPTH is a power of two so that address wrap is a mask
	localparam int RAM_DEPTH     = 65536;
	localparam int RAM_AW        = $clog2(RAM_DEPTH);
	localparam int PALETTE_BASE  = 64768;
	localparam int PALETTE_COUNT = 256;
	localparam int PALETTE_END   = PALETTE_BASE + 3 * PALETTE_COUNT;
	localparam int REG_COUNT     = 256;
	localparam int REG_AW        = $clog2(REG_COUNT);

	// Request functions
	localparam logic [2:0] FN_WRITE = 3'd0;
	localparam logic [2:0] FN_EXEC  = 3'd1;
	localparam logic [2:0] FN_RDREG = 3'd2;
	localparam logic [2:0] FN_RDRAM = 3'd3;
	localparam logic [2:0] FN_RESET = 3'd4;

	// Opcodes
	localparam logic [7:0] OP_HALT    = 8'd0;
	localparam logic [7:0] OP_JMP     = 8'd1;
	localparam logic [7:0] OP_JZ      = 8'd2;
	localparam logic [7:0] OP_JNZ     = 8'd3;
	localparam logic [7:0] OP_LD32    = 8'd4;
	localparam logic [7:0] OP_LD8     = 8'd5;
	localparam logic [7:0] OP_LD32P   = 8'd6;
	localparam logic [7:0] OP_LD8P    = 8'd7;
	localparam logic [7:0] OP_ST32    = 8'd8;
	localparam logic [7:0] OP_ST8     = 8'd9;
	localparam logic [7:0] OP_STR32P  = 8'd10;
	localparam logic [7:0] OP_STR8P   = 8'd11;
	localparam logic [7:0] OP_SETW    = 8'd12;
	localparam logic [7:0] OP_SET8    = 8'd13;
	localparam logic [7:0] OP_COPY    = 8'd14;
	localparam logic [7:0] OP_ADD     = 8'd15;
	localparam logic [7:0] OP_SUB     = 8'd16;
	localparam logic [7:0] OP_MUL     = 8'd17;
	localparam logic [7:0] OP_DIV     = 8'd18;
	localparam logic [7:0] OP_AND     = 8'd19;
	localparam logic [7:0] OP_OR      = 8'd20;
	localparam logic [7:0] OP_XOR     = 8'd21;
	localparam logic [7:0] OP_NOT     = 8'd22;
	localparam logic [7:0] OP_SHL     = 8'd23;
	localparam logic [7:0] OP_SHR     = 8'd24;

	typedef logic [RAM_AW-1:0] ram_addr_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] location;
		logic [7:0]  byte_in;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        halted;
		logic [15:0] next_pc;
	} rsp_t;

	// Wrap a byte address at the RAM size
	function automatic ram_addr_t ram_addr(input logic [31:0] a);
		return a[RAM_AW-1:0];
	endfunction

	// Widen a 3-bit color channel by bit replication
	function automatic logic [7:0] widen3(input logic [2:0] v);
		return {v, v, v[2:1]};
	endfunction

	// Widen a 2-bit color channel by bit replication
	function automatic logic [7:0] widen2(input logic [1:0] v);
		return {v, v, v, v};
	endfunction

endpackage

FILE: rtl/core/byte_code_register_machine_core_top.sv
// Top level of the byte-code register machine: sequencer around RAM and register file.
//
//  channel | dir | handshake                  | payload
//  in      | in  | in_valid / in_ready        | in_data  (func, location, byte_in)
//  out     | out | out_valid / out_ready      | out_data (read_data, halted, next_pc)
//
// An instruction fetches its opcode and operand bytes, reads its register operands and executes;
// loads then read their data bytes, stores write theirs, DIV waits on the divider, and a
// register result is written back before the response is handed on.
// Reset and the reset request sweep the whole RAM, one byte a cycle, clearing registers and
// writing the palette; no request is taken during the sweep.
// A finished response waits in the output register; a new request is taken meanwhile,
// and is held at its end until it drains.
`timescale 1ns / 1ps
module byte_code_register_machine_core_top import bcr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RDW, ST_OPC, ST_OPCW, ST_OPND, ST_EX0, ST_EX1, ST_EX2,
		ST_EX3, ST_MRD, ST_MRDW, ST_MWR, ST_DIVW, ST_WB, ST_DONE
	} state_t;

	state_t      state_q;
	logic [15:0] pc_q;
	logic        halt_q;
	logic        clr_rsp_q;
	ram_addr_t   clr_q;
	logic [7:0]  pal_i_q;
	logic [1:0]  pal_k_q;
	logic [31:0] rd_q;
	logic        rd_mem_q;
	logic [7:0]  op_q;
	logic [39:0] opnd_q;
	logic [2:0]  left_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] res_q;
	logic [7:0]  wd_q;
	logic [31:0] maddr_q;
	logic [31:0] wdat_q;
	logic [2:0]  mleft_q;

	logic        ram_we;
	ram_addr_t   ram_waddr;
	logic [7:0]  ram_wdata;
	ram_addr_t   ram_raddr;
	logic [7:0]  ram_rdata;
	logic        rf_we;
	logic [REG_AW-1:0] rf_waddr;
	logic [31:0] rf_wdata;
	logic [REG_AW-1:0] rf_raddr;
	logic [31:0] rf_rdata;

	logic        accept;
	logic        pal_hit;
	logic [7:0]  pal_byte;
	logic [7:0]  ra;
	logic [7:0]  rb;
	logic [2:0]  n_opnd;
	logic [31:0] alu_res;
	logic        div_start;
	logic        div_done;
	logic [31:0] div_q;

	bcr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	bcr_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regs (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_raddr), .rdata(rf_rdata)
	);

	bcr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(a_q), .divisor(b_q),
		.done(div_done), .quotient(div_q)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign div_start = (state_q == ST_EX3) && (op_q == OP_DIV);

	// Palette byte for the current sweep address
	assign pal_hit = ({{(32-RAM_AW){1'b0}}, clr_q} >= 32'(PALETTE_BASE)) &&
		({{(32-RAM_AW){1'b0}}, clr_q} < 32'(PALETTE_END));
	always_comb begin
		case (pal_k_q)
			2'd0:    pal_byte = widen3(pal_i_q[7:5]);
			2'd1:    pal_byte = widen3(pal_i_q[4:2]);
			default: pal_byte = widen2(pal_i_q[1:0]);
		endcase
	end

	// Operand byte count per opcode
	always_comb begin
		case (ram_rdata) inside
			OP_JMP:                                        n_opnd = 3'd4;
			OP_JZ, OP_JNZ, OP_LD32, OP_LD8,
			OP_ST32, OP_ST8, OP_SETW:                      n_opnd = 3'd5;
			OP_LD32P, OP_LD8P, OP_STR32P, OP_STR8P,
			OP_SET8, OP_COPY, OP_NOT:                      n_opnd = 3'd2;
			[OP_ADD:OP_XOR], OP_SHL, OP_SHR:               n_opnd = 3'd3;
			default:                                       n_opnd = 3'd0;
		endcase
	end

	// Register operand selects
	always_comb begin
		ra = 8'd0;
		rb = 8'd0;
		case (op_q) inside
			OP_JZ, OP_JNZ:                ra = opnd_q[7:0];
			OP_LD32P, OP_LD8P:            ra = opnd_q[15:8];
			OP_ST32, OP_ST8:              ra = opnd_q[39:32];
			OP_STR32P, OP_STR8P: begin
				ra = opnd_q[15:8];
				rb = opnd_q[7:0];
			end
			OP_COPY:                      ra = opnd_q[15:8];
			OP_NOT:                       ra = opnd_q[7:0];
			[OP_ADD:OP_XOR], OP_SHL, OP_SHR: begin
				ra = opnd_q[15:8];
				rb = opnd_q[7:0];
			end
			default: ;
		endcase
	end

	// ALU for all two-operand ops but divide
	always_comb begin
		case (op_q)
			OP_ADD:  alu_res = a_q + b_q;
			OP_SUB:  alu_res = a_q - b_q;
			OP_MUL:  alu_res = a_q * b_q;
			OP_AND:  alu_res = a_q & b_q;
			OP_OR:   alu_res = a_q | b_q;
			OP_XOR:  alu_res = a_q ^ b_q;
			OP_SHL:  alu_res = (b_q >= 32'd32) ? 32'd0 : a_q << b_q[4:0];
			default: alu_res = (b_q >= 32'd32) ? 32'd0 : a_q >> b_q[4:0];
		endcase
	end

	// Steer the RAM and register file ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 8'd0;
		ram_raddr = ram_addr({16'd0, pc_q});
		rf_we     = 1'b0;
		rf_waddr  = clr_q[REG_AW-1:0];
		rf_wdata  = 32'd0;
		rf_raddr  = ra[REG_AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = pal_hit ? pal_byte : 8'd0;
				rf_we     = ({{(32-RAM_AW){1'b0}}, clr_q} < 32'(REG_COUNT));
			end
			ST_IDLE: begin
				if (accept && in_data.func == FN_WRITE) begin
					ram_we    = 1'b1;
					ram_waddr = ram_addr({16'd0, in_data.location});
					ram_wdata = in_data.byte_in;
				end
				rf_raddr  = in_data.location[REG_AW-1:0];
				ram_raddr = ram_addr({16'd0, in_data.location});
			end
			ST_EX1:  rf_raddr = rb[REG_AW-1:0];
			ST_MRD, ST_MRDW: ram_raddr = ram_addr(maddr_q);
			ST_MWR: begin
				ram_we    = 1'b1;
				ram_waddr = ram_addr(maddr_q);
				ram_wdata = wdat_q[31:24];
			end
			ST_WB: begin
				rf_we    = 1'b1;
				rf_waddr = wd_q[REG_AW-1:0];
				rf_wdata = res_q;
			end
			default: ;
		endcase
	end

	// Sequencer: state, machine registers and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			pc_q      <= 16'd0;
			halt_q    <= 1'b0;
			clr_rsp_q <= 1'b0;
			clr_q     <= '0;
			pal_i_q   <= 8'd0;
			pal_k_q   <= 2'd0;
			out_valid <= 1'b0;
			left_q    <= 3'd0;
			mleft_q   <= 3'd0;
		end else begin
			// Drop the response once taken, unless a new one replaces it
			if (out_valid && out_ready && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (pal_hit) begin
						if (pal_k_q == 2'd2) begin
							pal_k_q <= 2'd0;
							pal_i_q <= pal_i_q + 8'd1;
						end else begin
							pal_k_q <= pal_k_q + 2'd1;
						end
					end
					clr_q <= clr_q + 1'b1;
					if (clr_q == RAM_AW'(RAM_DEPTH - 1)) begin
						state_q <= clr_rsp_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rd_q     <= 32'd0;
						rd_mem_q <= (in_data.func == FN_RDRAM);
						case (in_data.func)
							FN_EXEC:  state_q <= ST_OPC;
							FN_RDREG: state_q <= (in_data.location < 16'(REG_COUNT)) ?
								ST_RDW : ST_DONE;
							FN_RDRAM: state_q <= ST_RDW;
							FN_RESET: begin
								state_q   <= ST_CLEAR;
								clr_rsp_q <= 1'b1;
								clr_q     <= '0;
								pal_i_q   <= 8'd0;
								pal_k_q   <= 2'd0;
								pc_q      <= 16'd0;
								halt_q    <= 1'b0;
							end
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_RDW: begin
					rd_q    <= rd_mem_q ? {24'd0, ram_rdata} : rf_rdata;
					state_q <= ST_DONE;
				end
				// Fetch opcode and stream operand bytes
				ST_OPC: begin
					pc_q    <= pc_q + 16'd1;
					state_q <= ST_OPCW;
				end
				ST_OPCW: begin
					op_q   <= ram_rdata;
					opnd_q <= 40'd0;
					left_q <= n_opnd;
					if (n_opnd != 3'd0) begin
						pc_q    <= pc_q + 16'd1;
						state_q <= ST_OPND;
					end else begin
						state_q <= ST_EX0;
					end
				end
				ST_OPND: begin
					opnd_q <= {opnd_q[31:0], ram_rdata};
					if (left_q > 3'd1) begin
						left_q <= left_q - 3'd1;
						pc_q   <= pc_q + 16'd1;
					end else begin
						state_q <= ST_EX0;
					end
				end
				// Read both register operands
				ST_EX0: state_q <= ST_EX1;
				ST_EX1: begin
					a_q     <= rf_rdata;
					state_q <= ST_EX2;
				end
				ST_EX2: begin
					b_q     <= rf_rdata;
					state_q <= ST_EX3;
				end
				// Execute
				ST_EX3: begin
					state_q <= ST_DONE;
					case (op_q) inside
						OP_HALT: halt_q <= 1'b1;
						OP_JMP:  pc_q <= opnd_q[15:0];
						OP_JZ, OP_JNZ: begin
							if ((a_q == 32'd0) == (op_q == OP_JZ)) begin
								pc_q <= opnd_q[23:8];
							end
						end
						OP_LD32, OP_LD8: begin
							maddr_q <= opnd_q[39:8];
							wd_q    <= opnd_q[7:0];
							mleft_q <= (op_q == OP_LD32) ? 3'd4 : 3'd1;
							res_q   <= 32'd0;
							state_q <= ST_MRD;
						end
						OP_LD32P, OP_LD8P: begin
							maddr_q <= a_q;
							wd_q    <= opnd_q[7:0];
							mleft_q <= (op_q == OP_LD32P) ? 3'd4 : 3'd1;
							res_q   <= 32'd0;
							state_q <= ST_MRD;
						end
						OP_ST32, OP_ST8: begin
							maddr_q <= opnd_q[31:0];
							wdat_q  <= (op_q == OP_ST32) ? a_q : {a_q[7:0], 24'd0};
							mleft_q <= (op_q == OP_ST32) ? 3'd4 : 3'd1;
							state_q <= ST_MWR;
						end
						OP_STR32P, OP_STR8P: begin
							maddr_q <= b_q;
							wdat_q  <= (op_q == OP_STR32P) ? a_q : {a_q[7:0], 24'd0};
							mleft_q <= (op_q == OP_STR32P) ? 3'd4 : 3'd1;
							state_q <= ST_MWR;
						end
						OP_SETW: begin
							wd_q    <= opnd_q[39:32];
							res_q   <= opnd_q[31:0];
							state_q <= ST_WB;
						end
						OP_SET8: begin
							wd_q    <= opnd_q[15:8];
							res_q   <= {24'd0, opnd_q[7:0]};
							state_q <= ST_WB;
						end
						OP_COPY: begin
							wd_q    <= opnd_q[7:0];
							res_q   <= a_q;
							state_q <= ST_WB;
						end
						OP_NOT: begin
							wd_q    <= opnd_q[15:8];
							res_q   <= ~a_q;
							state_q <= ST_WB;
						end
						OP_DIV: begin
							wd_q    <= opnd_q[23:16];
							state_q <= ST_DIVW;
						end
						[OP_ADD:OP_XOR], OP_SHL, OP_SHR: begin
							wd_q    <= opnd_q[23:16];
							res_q   <= alu_res;
							state_q <= ST_WB;
						end
						default: ;
					endcase
				end
				// Data byte reads, one per cycle
				ST_MRD: begin
					maddr_q <= maddr_q + 32'd1;
					state_q <= ST_MRDW;
				end
				ST_MRDW: begin
					res_q <= {res_q[23:0], ram_rdata};
					if (mleft_q > 3'd1) begin
						mleft_q <= mleft_q - 3'd1;
						maddr_q <= maddr_q + 32'd1;
					end else begin
						state_q <= ST_WB;
					end
				end
				// Data byte writes, top byte first
				ST_MWR: begin
					wdat_q  <= {wdat_q[23:0], 8'd0};
					maddr_q <= maddr_q + 32'd1;
					if (mleft_q > 3'd1) begin
						mleft_q <= mleft_q - 3'd1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						res_q   <= div_q;
						state_q <= ST_WB;
					end
				end
				ST_WB: state_q <= ST_DONE;
				// Hand the response to the output register once it is free
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid          <= 1'b1;
						out_data.read_data <= rd_q;
						out_data.halted    <= halt_q;
						out_data.next_pc   <= pc_q;
						clr_rsp_q          <= 1'b0;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/bcr_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/bcr_div.sv
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bcr_div import bcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] shifted;
	logic        fits;

	// Shift in the next dividend bit and compare against the divisor
	assign shifted  = {rem_q[31:0], quo_q[31]};
	assign fits     = shifted >= {1'b0, dvs_q};
	assign quotient = quo_q;

	// Iterate; a zero divisor gives all ones naturally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? shifted - {1'b0, dvs_q} : shifted;
				quo_q <= {quo_q[30:0], fits};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule
